// ===== rtl/core/pva_pkg.sv =====
// Shared types and constants for the polyphonic voice allocator.
package pva_pkg;

  // Block geometry.
  localparam int CHANNELS  = 16;
  localparam int VOICES    = 16;
  localparam int PITCHES   = 128;
  localparam int CH_W      = 4;
  localparam int PITCH_W   = 7;
  localparam int TIME_W    = 31;
  localparam int VOICE_W   = 4;
  localparam int PEAK_W    = 5;
  localparam int MAP_AW    = CH_W + PITCH_W;
  localparam int MAP_DEPTH = CHANNELS * PITCHES;
  localparam int GRP       = 4;
  localparam int NGRP      = (VOICES + GRP - 1) / GRP;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_BEGIN    = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_OTHER    = 2'd3
  } cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_COMMIT
  } state_t;

  // One row of slot times for a channel.
  typedef logic [VOICES-1:0][TIME_W-1:0] trow_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic commit;
    logic sweep;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_begin;
    logic sweep_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/pva_ctrl.sv =====
// Controller state machine for the polyphonic voice allocator.
module pva_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pva_pkg::dp_stat_t stat,
  output pva_pkg::dp_ctrl_t ctrl
);

  pva_pkg::state_t state_r, state_nxt;

  // State register; reset starts the map clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pva_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pva_pkg::S_CLEAR: begin
        if (stat.sweep_last) state_nxt = pva_pkg::S_IDLE;
      end
      pva_pkg::S_IDLE: begin
        if (start) state_nxt = pva_pkg::S_READ;
      end
      pva_pkg::S_READ: begin
        state_nxt = pva_pkg::S_COMMIT;
      end
      pva_pkg::S_COMMIT: begin
        state_nxt = stat.is_begin ? pva_pkg::S_CLEAR : pva_pkg::S_IDLE;
      end
      default: state_nxt = pva_pkg::S_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    busy        = (state_r != pva_pkg::S_IDLE);
    ctrl.load   = (state_r == pva_pkg::S_IDLE) && start;
    ctrl.commit = (state_r == pva_pkg::S_COMMIT);
    ctrl.sweep  = (state_r == pva_pkg::S_CLEAR);
  end

endmodule

// ===== rtl/core/pva_dp.sv =====
// Datapath of the polyphonic voice allocator: slot tables, pitch map, peaks.
module pva_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pva_pkg::dp_ctrl_t            ctrl,
  output pva_pkg::dp_stat_t            stat,
  input  logic [1:0]                   in_command,
  input  logic [pva_pkg::CH_W-1:0]     in_channel,
  input  logic [pva_pkg::PITCH_W-1:0]  in_pitch,
  input  logic [pva_pkg::TIME_W-1:0]   in_start_time,
  input  logic [pva_pkg::TIME_W-1:0]   in_end_time,
  output logic                         out_valid,
  output logic [pva_pkg::VOICE_W-1:0]  out_voice,
  output logic [pva_pkg::PEAK_W-1:0]   out_peak_voices,
  output logic                         out_stolen,
  output logic                         out_error
);

  // Latched input beat.
  pva_pkg::cmd_t                  cmd_r;
  logic [pva_pkg::CH_W-1:0]       ch_r;
  logic [pva_pkg::PITCH_W-1:0]    pitch_r;
  logic [pva_pkg::TIME_W-1:0]     st_r;
  logic [pva_pkg::TIME_W-1:0]     en_r;

  // Memories and their registered read data.
  pva_pkg::trow_t                 start_mem [pva_pkg::CHANNELS];
  pva_pkg::trow_t                 end_mem   [pva_pkg::CHANNELS];
  logic [pva_pkg::VOICE_W:0]      map_mem   [pva_pkg::MAP_DEPTH];
  pva_pkg::trow_t                 srow_r, erow_r;
  logic [pva_pkg::VOICE_W:0]      map_rd_r;

  // Flip-flop state.
  logic [pva_pkg::VOICES-1:0]     busy_r [pva_pkg::CHANNELS];
  logic [pva_pkg::PEAK_W-1:0]     peak_r [pva_pkg::CHANNELS];
  logic [pva_pkg::MAP_AW-1:0]     sweep_r;

  // First evaluation stage.
  logic [pva_pkg::VOICES-1:0]     live_r, live_nxt;
  logic [pva_pkg::TIME_W-1:0]     gmin_r [pva_pkg::NGRP];
  logic [pva_pkg::VOICE_W-1:0]    gidx_r [pva_pkg::NGRP];
  logic [pva_pkg::TIME_W-1:0]     gmin_nxt [pva_pkg::NGRP];
  logic [pva_pkg::VOICE_W-1:0]    gidx_nxt [pva_pkg::NGRP];

  // Commit stage values.
  logic                           ch_ok;
  logic                           steal;
  logic                           found;
  logic [pva_pkg::VOICE_W-1:0]    pick;
  logic [pva_pkg::VOICE_W-1:0]    free_idx;
  logic [pva_pkg::TIME_W-1:0]     oldest;
  logic [pva_pkg::VOICE_W-1:0]    oldest_idx;
  logic [pva_pkg::PEAK_W-1:0]     count;
  logic [pva_pkg::PEAK_W-1:0]     cur_peak;
  logic [pva_pkg::PEAK_W-1:0]     new_peak;
  logic [pva_pkg::VOICES-1:0]     busy_row;
  logic [pva_pkg::VOICES-1:0]     busy_row_nxt;
  pva_pkg::trow_t                 srow_nxt, erow_nxt;

  // Registered result.
  logic                           out_valid_r;
  logic [pva_pkg::VOICE_W-1:0]    out_voice_r, out_voice_nxt;
  logic [pva_pkg::PEAK_W-1:0]     out_peak_r, out_peak_nxt;
  logic                           out_stolen_r, out_stolen_nxt;
  logic                           out_error_r, out_error_nxt;

  assign ch_ok    = ({1'b0, ch_r} < (pva_pkg::CH_W + 1)'(pva_pkg::CHANNELS));
  assign busy_row = ch_ok ? busy_r[ch_r] : '0;
  assign cur_peak = ch_ok ? peak_r[ch_r] : '0;

  // Capture the input beat and read all memories at the accepted address.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r    <= pva_pkg::cmd_t'(in_command);
      ch_r     <= in_channel;
      pitch_r  <= in_pitch;
      st_r     <= in_start_time;
      en_r     <= in_end_time;
      srow_r   <= start_mem[in_channel];
      erow_r   <= end_mem[in_channel];
      map_rd_r <= map_mem[{in_channel, in_pitch}];
    end
  end

  // Stage one: free expired slots and reduce start times in groups of four.
  always_comb begin
    for (int v = 0; v < pva_pkg::VOICES; v++) begin
      live_nxt[v] = busy_row[v] && !(erow_r[v] <= st_r);
    end
    for (int g = 0; g < pva_pkg::NGRP; g++) begin
      gmin_nxt[g] = srow_r[g * pva_pkg::GRP];
      gidx_nxt[g] = pva_pkg::VOICE_W'(g * pva_pkg::GRP);
      for (int k = 1; k < pva_pkg::GRP; k++) begin
        if ((g * pva_pkg::GRP + k) < pva_pkg::VOICES) begin
          if (srow_r[g * pva_pkg::GRP + k] < gmin_nxt[g]) begin
            gmin_nxt[g] = srow_r[g * pva_pkg::GRP + k];
            gidx_nxt[g] = pva_pkg::VOICE_W'(g * pva_pkg::GRP + k);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    live_r <= live_nxt;
    for (int g = 0; g < pva_pkg::NGRP; g++) begin
      gmin_r[g] <= gmin_nxt[g];
      gidx_r[g] <= gidx_nxt[g];
    end
  end

  // Stage two: pick the first free slot or the oldest busy one.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int v = 0; v < pva_pkg::VOICES; v++) begin
      if (!found && !live_r[v]) begin
        found    = 1'b1;
        free_idx = pva_pkg::VOICE_W'(v);
      end
    end
    oldest     = gmin_r[0];
    oldest_idx = gidx_r[0];
    for (int g = 1; g < pva_pkg::NGRP; g++) begin
      if (gmin_r[g] < oldest) begin
        oldest     = gmin_r[g];
        oldest_idx = gidx_r[g];
      end
    end
    steal = !found;
    pick  = steal ? oldest_idx : free_idx;
    count = steal ? pva_pkg::PEAK_W'(pva_pkg::VOICES)
                  : pva_pkg::PEAK_W'($countones(live_r) + 1);
    new_peak = (count > cur_peak) ? count : cur_peak;
    for (int v = 0; v < pva_pkg::VOICES; v++) begin
      busy_row_nxt[v] = live_r[v] || (pick == pva_pkg::VOICE_W'(v));
      srow_nxt[v] = (pick == pva_pkg::VOICE_W'(v)) ? st_r : srow_r[v];
      erow_nxt[v] = (pick == pva_pkg::VOICE_W'(v)) ? en_r : erow_r[v];
    end
  end

  // Result of the beat being committed.
  always_comb begin
    out_voice_nxt  = '0;
    out_peak_nxt   = '0;
    out_stolen_nxt = 1'b0;
    out_error_nxt  = 1'b0;
    case (cmd_r)
      pva_pkg::CMD_BEGIN: begin
        out_peak_nxt = '0;
      end
      pva_pkg::CMD_NOTE_ON: begin
        if (ch_ok) begin
          out_voice_nxt  = pick;
          out_peak_nxt   = new_peak;
          out_stolen_nxt = steal;
        end
      end
      pva_pkg::CMD_NOTE_OFF: begin
        if (ch_ok) begin
          out_peak_nxt = cur_peak;
          if (map_rd_r[pva_pkg::VOICE_W]) begin
            out_voice_nxt = map_rd_r[pva_pkg::VOICE_W-1:0];
          end else begin
            out_error_nxt = 1'b1;
          end
        end
      end
      default: begin
        out_peak_nxt = cur_peak;
      end
    endcase
  end

  // Slot time rows: written back only by a note on.
  always_ff @(posedge clk) begin
    if (ctrl.commit && (cmd_r == pva_pkg::CMD_NOTE_ON) && ch_ok) begin
      start_mem[ch_r] <= srow_nxt;
      end_mem[ch_r]   <= erow_nxt;
    end
  end

  // Pitch map: clearing sweep, note on record, note off release.
  always_ff @(posedge clk) begin
    if (ctrl.sweep) begin
      map_mem[sweep_r] <= '0;
    end else if (ctrl.commit && ch_ok) begin
      if (cmd_r == pva_pkg::CMD_NOTE_ON) begin
        map_mem[{ch_r, pitch_r}] <= {1'b1, pick};
      end else if (cmd_r == pva_pkg::CMD_NOTE_OFF) begin
        map_mem[{ch_r, pitch_r}] <= '0;
      end
    end
  end

  // Busy flags and peaks: cleared at reset and by a begin beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < pva_pkg::CHANNELS; c++) begin
        busy_r[c] <= '0;
        peak_r[c] <= '0;
      end
    end else if (ctrl.commit) begin
      if (cmd_r == pva_pkg::CMD_BEGIN) begin
        for (int c = 0; c < pva_pkg::CHANNELS; c++) begin
          busy_r[c] <= '0;
          peak_r[c] <= '0;
        end
      end else if ((cmd_r == pva_pkg::CMD_NOTE_ON) && ch_ok) begin
        busy_r[ch_r] <= busy_row_nxt;
        peak_r[ch_r] <= new_peak;
      end
    end
  end

  // Sweep address for the map clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (ctrl.commit) begin
      sweep_r <= '0;
    end else if (ctrl.sweep) begin
      sweep_r <= sweep_r + 1'b1;
    end
  end

  assign stat.is_begin   = (cmd_r == pva_pkg::CMD_BEGIN);
  assign stat.sweep_last = (sweep_r == pva_pkg::MAP_AW'(pva_pkg::MAP_DEPTH - 1));

  // Output register: one strobe per committed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_voice_r  <= out_voice_nxt;
      out_peak_r   <= out_peak_nxt;
      out_stolen_r <= out_stolen_nxt;
      out_error_r  <= out_error_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_voice       = out_voice_r;
  assign out_peak_voices = out_peak_r;
  assign out_stolen      = out_stolen_r;
  assign out_error       = out_error_r;

`ifndef NO_ASSERTIONS
  a_strobe_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(ctrl.commit))
    else $error("result strobe without a commit");
  a_stolen_error_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_stolen_r && out_error_r))
    else $error("stolen and error both set");
  a_peak_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_peak_r <= pva_pkg::PEAK_W'(pva_pkg::VOICES)))
    else $error("peak count above voice count");
  a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.sweep |-> !ctrl.load && !ctrl.commit)
    else $error("beat taken during the map clearing pass");
`endif

endmodule

// ===== rtl/core/poly_voice_allocator_unit.sv =====
// Top level of the polyphonic voice allocator.
//
// Usage: present a note event on the in_ ports and raise start; the beat is
// taken at a rising edge where start is high and busy is low. Commands are
// begin (clear flags, peaks and map), note on, note off and other (no change).
// Each beat produces exactly one result, shown on the out_ ports for one
// cycle with out_valid high; the receiver cannot stall it.
// The accepted beat passes the memory read, the expiry check and group
// minimum, and the pick and write back; the result is then registered and
// shown with out_valid high.
// A new beat is taken only after the last one is committed; except after a
// begin, the result cycle overlaps the next accept. A note on checks all
// slots of its channel in parallel. Reset and every begin beat start a
// clearing pass over the 2048-entry pitch map, one entry a cycle, so busy
// stays high after reset and after a begin result until the map is clear.
// Slot flags and peaks clear at once. Slot start and end times are not
// cleared; they are read only while the slot is busy.
module poly_voice_allocator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [pva_pkg::CH_W-1:0]     in_channel,
  input  logic [pva_pkg::PITCH_W-1:0]  in_pitch,
  input  logic [pva_pkg::TIME_W-1:0]   in_start_time,
  input  logic [pva_pkg::TIME_W-1:0]   in_end_time,
  output logic                         out_valid,
  output logic [pva_pkg::VOICE_W-1:0]  out_voice,
  output logic [pva_pkg::PEAK_W-1:0]   out_peak_voices,
  output logic                         out_stolen,
  output logic                         out_error
);

  pva_pkg::dp_ctrl_t ctrl;
  pva_pkg::dp_stat_t stat;

  // Sequencer.
  pva_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Tables and result register.
  pva_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_command      (in_command),
    .in_channel      (in_channel),
    .in_pitch        (in_pitch),
    .in_start_time   (in_start_time),
    .in_end_time     (in_end_time),
    .out_valid       (out_valid),
    .out_voice       (out_voice),
    .out_peak_voices (out_peak_voices),
    .out_stolen      (out_stolen),
    .out_error       (out_error)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the polyphonic voice allocator unit.
module testbench;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_command;
  logic [pva_pkg::CH_W-1:0] in_channel;
  logic [pva_pkg::PITCH_W-1:0] in_pitch;
  logic [pva_pkg::TIME_W-1:0] in_start_time;
  logic [pva_pkg::TIME_W-1:0] in_end_time;
  logic out_valid;
  logic [pva_pkg::VOICE_W-1:0] out_voice;
  logic [pva_pkg::PEAK_W-1:0] out_peak_voices;
  logic out_stolen;
  logic out_error;

  typedef struct packed {
    logic [pva_pkg::VOICE_W-1:0] voice;
    logic [pva_pkg::PEAK_W-1:0] peak;
    logic stolen;
    logic error;
  } alloc_result_t;

  // Predicted state of the allocator.
  logic slot_held [pva_pkg::CHANNELS][pva_pkg::VOICES];
  logic [pva_pkg::TIME_W-1:0] slot_t0 [pva_pkg::CHANNELS][pva_pkg::VOICES];
  logic [pva_pkg::TIME_W-1:0] slot_t1 [pva_pkg::CHANNELS][pva_pkg::VOICES];
  logic note_held [pva_pkg::CHANNELS][pva_pkg::PITCHES];
  logic [pva_pkg::VOICE_W-1:0] note_voice [pva_pkg::CHANNELS][pva_pkg::PITCHES];
  logic [pva_pkg::PEAK_W-1:0] peak_count [pva_pkg::CHANNELS];

  alloc_result_t pending_allocs[$];
  int n_fail;
  int n_beats;
  int n_checked;
  int n_steals;
  int n_orphans;
  int idle_cycles;
  logic [pva_pkg::TIME_W-1:0] clock_ticks [pva_pkg::CHANNELS];

  poly_voice_allocator_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clear the predicted tables, as reset and a begin beat do.
  function automatic void clear_tables();
    for (int c = 0; c < pva_pkg::CHANNELS; c++) begin
      peak_count[c] = '0;
      for (int v = 0; v < pva_pkg::VOICES; v++) slot_held[c][v] = 1'b0;
      for (int p = 0; p < pva_pkg::PITCHES; p++) note_held[c][p] = 1'b0;
    end
  endfunction

  // Work out the result of one event and update the predicted tables.
  function automatic alloc_result_t allocate_voice(pva_pkg::cmd_t cmd, int ch, int p,
      logic [pva_pkg::TIME_W-1:0] t0, logic [pva_pkg::TIME_W-1:0] t1);
    alloc_result_t r;
    int cnt;
    int pick;
    logic [pva_pkg::TIME_W-1:0] oldest;
    r = '0;
    if (cmd == pva_pkg::CMD_BEGIN) begin
      clear_tables();
    end else if (cmd == pva_pkg::CMD_OTHER) begin
      r.peak = peak_count[ch];
    end else if (cmd == pva_pkg::CMD_NOTE_ON) begin
      cnt = 1;
      pick = 0;
      for (int v = 0; v < pva_pkg::VOICES; v++) begin
        if (slot_held[ch][v]) begin
          if (slot_t1[ch][v] <= t0) slot_held[ch][v] = 1'b0;
          else cnt++;
        end
      end
      if (cnt > pva_pkg::VOICES) begin
        oldest = slot_t0[ch][0];
        for (int v = 1; v < pva_pkg::VOICES; v++) begin
          if (slot_t0[ch][v] < oldest) begin
            oldest = slot_t0[ch][v];
            pick = v;
          end
        end
        r.stolen = 1'b1;
        cnt = pva_pkg::VOICES;
      end else begin
        for (int v = pva_pkg::VOICES - 1; v >= 0; v--) if (!slot_held[ch][v]) pick = v;
      end
      slot_held[ch][pick] = 1'b1;
      slot_t0[ch][pick] = t0;
      slot_t1[ch][pick] = t1;
      if (cnt > peak_count[ch]) peak_count[ch] = pva_pkg::PEAK_W'(cnt);
      note_held[ch][p] = 1'b1;
      note_voice[ch][p] = pva_pkg::VOICE_W'(pick);
      r.voice = pva_pkg::VOICE_W'(pick);
      r.peak = peak_count[ch];
    end else begin
      if (note_held[ch][p]) begin
        r.voice = note_voice[ch][p];
        note_held[ch][p] = 1'b0;
      end else begin
        r.error = 1'b1;
      end
      r.peak = peak_count[ch];
    end
    return r;
  endfunction

  // Random nonzero gap: mostly short, sometimes long.
  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) n = 1;
    repeat (n) @(posedge clk);
  endtask

  // Send one beat and record its prediction once it is taken.
  task automatic send_event(pva_pkg::cmd_t cmd, int ch, int p,
      logic [pva_pkg::TIME_W-1:0] t0, logic [pva_pkg::TIME_W-1:0] t1);
    in_command <= cmd;
    in_channel <= pva_pkg::CH_W'(ch);
    in_pitch <= pva_pkg::PITCH_W'(p);
    in_start_time <= t0;
    in_end_time <= t1;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_allocs.push_back(allocate_voice(cmd, ch, p, t0, t1));
    if (pending_allocs[$].stolen) n_steals++;
    if (pending_allocs[$].error) n_orphans++;
    n_beats++;
    start <= 1'b0;
    sender_gap();
  endtask

  task automatic wait_drained();
    while (pending_allocs.size() != 0) @(posedge clk);
  endtask

  // Note on at the channel's running clock.
  task automatic play_note(int ch, int p, int len);
    logic [pva_pkg::TIME_W-1:0] t0;
    t0 = clock_ticks[ch];
    clock_ticks[ch] = pva_pkg::TIME_W'(t0 + $urandom_range(0, 3));
    send_event(pva_pkg::CMD_NOTE_ON, ch, p, t0, pva_pkg::TIME_W'(t0 + len));
  endtask

  // Extremes of the fields and every command.
  task automatic test_directed();
    send_event(pva_pkg::CMD_OTHER, 15, 127, '1, '1);
    send_event(pva_pkg::CMD_NOTE_OFF, 0, 0, 0, 0);
    send_event(pva_pkg::CMD_NOTE_ON, 0, 127, 0, '1);
    send_event(pva_pkg::CMD_NOTE_ON, 15, 0, '1, '1);
    send_event(pva_pkg::CMD_NOTE_OFF, 0, 127, 0, 0);
    send_event(pva_pkg::CMD_NOTE_OFF, 0, 127, 0, 0);
    send_event(pva_pkg::CMD_OTHER, 0, 0, 0, 0);
    send_event(pva_pkg::CMD_NOTE_ON, 15, 1, '1, 0);
    send_event(pva_pkg::CMD_NOTE_ON, 15, 1, 31'h2AAAAAAA, 31'h55555555);
    send_event(pva_pkg::CMD_NOTE_OFF, 15, 1, '1, '1);
    send_event(pva_pkg::CMD_BEGIN, 7, 64, 31'h55555555, 31'h2AAAAAAA);
    send_event(pva_pkg::CMD_OTHER, 15, 0, 0, 0);
    send_event(pva_pkg::CMD_NOTE_OFF, 15, 1, 0, 0);
  endtask

  // Fill one channel past its voices to force steals, with start time ties.
  task automatic test_steal();
    for (int i = 0; i < pva_pkg::VOICES + 4; i++)
      send_event(pva_pkg::CMD_NOTE_ON, 3, i,
                 pva_pkg::TIME_W'((i < 4) ? 100 : 100 + i), 31'd100000);
    send_event(pva_pkg::CMD_NOTE_OFF, 3, 0, 0, 0);
    send_event(pva_pkg::CMD_NOTE_ON, 3, 50, 31'd100000, 31'd100010);
    send_event(pva_pkg::CMD_OTHER, 3, 0, 0, 0);
    wait_drained();
  endtask

  // Random streams: mostly time-ordered notes, some noise.
  task automatic test_random(int count);
    int ch;
    int p;
    int k;
    for (int c = 0; c < pva_pkg::CHANNELS; c++)
      clock_ticks[c] = pva_pkg::TIME_W'($urandom_range(0, 1000));
    for (int i = 0; i < count; i++) begin
      ch = $urandom_range(0, 2) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 1);
      p = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(60, 67);
      k = $urandom_range(0, 99);
      if (k < 55) play_note(ch, p, $urandom_range(1, 80));
      else if (k < 80) send_event(pva_pkg::CMD_NOTE_OFF, ch, p, clock_ticks[ch], 0);
      else if (k < 88)
        send_event(pva_pkg::CMD_OTHER, ch, p, pva_pkg::TIME_W'($urandom),
                   pva_pkg::TIME_W'($urandom));
      else if (k < 96)
        send_event(pva_pkg::CMD_NOTE_ON, ch, p, pva_pkg::TIME_W'($urandom),
                   pva_pkg::TIME_W'($urandom));
      else if (k < 98)
        send_event(pva_pkg::CMD_BEGIN, ch, p, pva_pkg::TIME_W'($urandom),
                   pva_pkg::TIME_W'($urandom));
      else wait_drained();
    end
  endtask

  // Check every result against the oldest prediction.
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      if (pending_allocs.size() == 0) begin
        $error("result with no pending event");
        n_fail++;
      end else begin
        e = pending_allocs.pop_front();
        n_checked++;
        if (out_voice !== e.voice) begin
          $error("voice: expected %0d, got %0d", e.voice, out_voice);
          n_fail++;
        end
        if (out_peak_voices !== e.peak) begin
          $error("peak_voices: expected %0d, got %0d", e.peak, out_peak_voices);
          n_fail++;
        end
        if (out_stolen !== e.stolen) begin
          $error("stolen: expected %0d, got %0d", e.stolen, out_stolen);
          n_fail++;
        end
        if (out_error !== e.error) begin
          $error("error: expected %0d, got %0d", e.error, out_error);
          n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat or result; it outlasts a clearing pass.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    n_beats = 0;
    n_steals = 0;
    n_orphans = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = pva_pkg::CMD_OTHER;
    in_channel = '0;
    in_pitch = '0;
    in_start_time = '0;
    in_end_time = '0;
    clear_tables();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_steal();
    test_random(820);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d beats, checked %0d results.", n_beats, n_checked);
    $display("Covered %0d steals and %0d unmatched note offs.", n_steals, n_orphans);
    if (n_fail == 0 && pending_allocs.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
